FILE: hdl/dht_pkg.sv
// Package for the double-hashing insert table: field widths, default sizes,
// result and request codes, and the state types of the controller and hash unit.
// No dependencies.
`default_nettype none

package dht_pkg;

  localparam int unsigned TABLE_SIZE_DEF   = 251;
  localparam int unsigned SECOND_PRIME_DEF = 241;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned STATUS_W = 2;

  // The hash unit folds this many key bits into each remainder per cycle.
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned HASH_W   = 32;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_READ     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_HASH,
    S_PROBE,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_KEY,
    HS_STEP
  } hash_state_e;

endpackage

`default_nettype wire

FILE: hdl/dht_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on dht_pkg for the field widths.
`default_nettype none

interface dht_in_if;
  import dht_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [KEY_W-1:0]  key;
  logic [SLOT_W-1:0] read_slot;

  modport source (output valid, kind, key, read_slot, input ready);
  modport sink   (input valid, kind, key, read_slot, output ready);
endinterface

interface dht_out_if;
  import dht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [KEY_W-1:0]    stored_key;
  logic                occupied;

  modport source (output valid, status, slot, stored_key, occupied, input ready);
  modport sink   (input valid, status, slot, stored_key, occupied, output ready);
endinterface

`default_nettype wire

FILE: hdl/dht_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies.
`default_nettype none

module dht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/dht_hash.sv
// Multi-cycle hash unit: computes the home slot (key mod table size) and the
// probe step ((prime - key mod prime) mod table size) by shift-and-subtract.
// Depends on dht_pkg.
`default_nettype none

module dht_hash #(
  parameter int unsigned TableSize   = dht_pkg::TABLE_SIZE_DEF,
  parameter int unsigned SecondPrime = dht_pkg::SECOND_PRIME_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [dht_pkg::KEY_W-1:0]    key_i,
  output      logic                         done_o,
  output      logic [$clog2(TableSize)-1:0] home_o,
  output      logic [$clog2(TableSize)-1:0] step_o
);
  import dht_pkg::*;

  localparam int unsigned AW          = $clog2(TableSize);
  localparam int unsigned SW          = $clog2(SecondPrime + 1);
  localparam int unsigned KEY_DIGITS  = HASH_W / DIGIT_W;
  localparam int unsigned STEP_DIGITS = (SW + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned CNT_W       = $clog2(KEY_DIGITS);

  hash_state_e         phase_q, phase_d;
  logic [HASH_W-1:0]   sh_q, sh_d;
  logic [AW-1:0]       rt_q, rt_d;
  logic [SW-1:0]       rs_q, rs_d;
  logic [AW-1:0]       home_q, home_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                done_q, done_d;

  // Next remainders after folding in the top DIGIT_W bits of the shifter.
  logic [AW-1:0]       rt_fold;
  logic [SW-1:0]       rs_fold;
  logic [SW-1:0]       step_raw;

  always_comb begin
    logic [AW:0] t_acc;
    logic [SW:0] s_acc;
    t_acc = {1'b0, rt_q};
    s_acc = {1'b0, rs_q};
    for (int j = 0; j < DIGIT_W; j++) begin
      t_acc = {t_acc[AW-1:0], sh_q[HASH_W-1-j]};
      if (t_acc >= (AW+1)'(TableSize)) begin
        t_acc = t_acc - (AW+1)'(TableSize);
      end
      s_acc = {s_acc[SW-1:0], sh_q[HASH_W-1-j]};
      if (s_acc >= (SW+1)'(SecondPrime)) begin
        s_acc = s_acc - (SW+1)'(SecondPrime);
      end
    end
    rt_fold = t_acc[AW-1:0];
    rs_fold = s_acc[SW-1:0];
  end

  // The step before reduction lies in 1..SecondPrime.
  assign step_raw = SW'(SecondPrime) - rs_fold;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      HS_IDLE: begin
        if (start_i) begin
          phase_d = HS_KEY;
        end
      end
      HS_KEY: begin
        if (cnt_q == CNT_W'(KEY_DIGITS - 1)) begin
          phase_d = HS_STEP;
        end
      end
      HS_STEP: begin
        if (cnt_q == CNT_W'(STEP_DIGITS - 1)) begin
          phase_d = HS_IDLE;
        end
      end
      default: phase_d = HS_IDLE;
    endcase
  end

  always_comb begin
    sh_d   = sh_q;
    rt_d   = rt_q;
    rs_d   = rs_q;
    home_d = home_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (phase_q)
      HS_IDLE: begin
        if (start_i) begin
          sh_d  = HASH_W'(key_i);
          rt_d  = '0;
          rs_d  = '0;
          cnt_d = '0;
        end
      end
      HS_KEY: begin
        sh_d  = sh_q << DIGIT_W;
        rt_d  = rt_fold;
        rs_d  = rs_fold;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(KEY_DIGITS - 1)) begin
          // Key fully folded: keep the home slot and reduce the step next.
          home_d = rt_fold;
          sh_d   = HASH_W'(step_raw) << (HASH_W - DIGIT_W * STEP_DIGITS);
          rt_d   = '0;
          cnt_d  = '0;
        end
      end
      HS_STEP: begin
        sh_d  = sh_q << DIGIT_W;
        rt_d  = rt_fold;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEP_DIGITS - 1)) begin
          done_d = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= HS_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    rt_q   <= rt_d;
    rs_q   <= rs_d;
    home_q <= home_d;
  end

  assign done_o = done_q;
  assign home_o = home_q;
  assign step_o = rt_q;

endmodule

`default_nettype wire

FILE: hdl/double_hash_table_insert.sv
// Channel     | Dir | Payload                                  | Transfer
// in_i        | in  | kind, key, read_slot                     | valid & ready
// out_o       | out | status, slot, stored_key, occupied       | valid & ready
//
// After reset a clearing pass writes every slot empty, with in_i.ready low.
// A read addresses the slot RAM on transfer and fills the result register in
// S_RDATA. An insert runs the hash unit (key fold, then step reduction) and
// probes the single-port slot RAM in S_PROBE before its result goes out. A full
// table rejects from S_IDLE. A result waits in place while out_o stalls.
// Depends on dht_pkg, dht_if, dht_ram and dht_hash.
`default_nettype none

module double_hash_table_insert #(
  parameter int unsigned TableSize   = dht_pkg::TABLE_SIZE_DEF,
  parameter int unsigned SecondPrime = dht_pkg::SECOND_PRIME_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dht_in_if.sink    in_i,
  dht_out_if.source out_o
);
  import dht_pkg::*;

  localparam int unsigned AW      = $clog2(TableSize);
  localparam int unsigned COUNT_W = $clog2(TableSize + 1);
  localparam int unsigned WORD_W  = KEY_W + 1;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       n_q, n_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [SLOT_W-1:0]   rslot_q, rslot_d;
  logic                rd_ok_q, rd_ok_d;

  status_e             res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;
  logic                res_occ_q, res_occ_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic                out_occ_q, out_occ_d;

  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                hash_start, hash_done;
  logic [AW-1:0]       hash_home, hash_step;

  logic                out_free;
  logic                slot_busy;
  logic [AW:0]         idx_sum;
  logic [AW-1:0]       idx_next;

  dht_ram #(
    .Width (WORD_W),
    .Depth (TableSize)
  ) u_slots (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  dht_hash #(
    .TableSize   (TableSize),
    .SecondPrime (SecondPrime)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_i.key),
    .done_o  (hash_done),
    .home_o  (hash_home),
    .step_o  (hash_step)
  );

  // The top bit of a RAM word marks the slot as occupied.
  assign slot_busy = ram_rdata[KEY_W];
  assign out_free  = !out_valid_q || out_o.ready;
  assign idx_sum   = {1'b0, idx_q} + {1'b0, hash_step};
  assign idx_next  = (idx_sum >= (AW+1)'(TableSize)) ?
                     AW'(idx_sum - (AW+1)'(TableSize)) : idx_sum[AW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(TableSize - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          if (kind_e'(in_i.kind) == KIND_READ) begin
            state_d = S_RDATA;
          end else if (count_q >= COUNT_W'(TableSize)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_RDATA: state_d = S_EMIT;
      S_HASH: begin
        if (hash_done) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!slot_busy || n_q == AW'(TableSize - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_d        = clr_q;
    idx_d        = idx_q;
    n_d          = n_q;
    count_d      = count_q;
    key_d        = key_q;
    rslot_d      = rslot_q;
    rd_ok_d      = rd_ok_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_key_d    = res_key_q;
    res_occ_d    = res_occ_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_key_d    = out_key_q;
    out_occ_d    = out_occ_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = '0;
    ram_wdata    = '0;
    hash_start   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_i.valid) begin
          key_d   = in_i.key;
          rslot_d = in_i.read_slot;
          if (kind_e'(in_i.kind) == KIND_READ) begin
            ram_en   = 1'b1;
            ram_addr = AW'(in_i.read_slot);
            rd_ok_d  = 32'(in_i.read_slot) < TableSize;
          end else if (count_q >= COUNT_W'(TableSize)) begin
            res_status_d = STATUS_REJECTED;
            res_slot_d   = '0;
            res_key_d    = '0;
            res_occ_d    = 1'b0;
          end else begin
            hash_start = 1'b1;
          end
        end
      end
      S_RDATA: begin
        res_status_d = STATUS_READ;
        res_slot_d   = rslot_q;
        res_occ_d    = rd_ok_q && slot_busy;
        res_key_d    = (rd_ok_q && slot_busy) ? ram_rdata[KEY_W-1:0] : '0;
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d    = hash_home;
          n_d      = '0;
          ram_en   = 1'b1;
          ram_addr = hash_home;
        end
      end
      S_PROBE: begin
        if (!slot_busy) begin
          ram_en       = 1'b1;
          ram_we       = 1'b1;
          ram_addr     = idx_q;
          ram_wdata    = {1'b1, key_q};
          count_d      = count_q + COUNT_W'(1);
          res_status_d = STATUS_INSERTED;
          res_slot_d   = SLOT_W'(idx_q);
          res_key_d    = key_q;
          res_occ_d    = 1'b1;
        end else if (n_q == AW'(TableSize - 1)) begin
          // Every probe position was taken: reject as for a full table.
          res_status_d = STATUS_REJECTED;
          res_slot_d   = '0;
          res_key_d    = '0;
          res_occ_d    = 1'b0;
        end else begin
          idx_d    = idx_next;
          n_d      = n_q + AW'(1);
          ram_en   = 1'b1;
          ram_addr = idx_next;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_key_d    = res_key_q;
          out_occ_d    = res_occ_q;
        end
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    n_q          <= n_d;
    key_q        <= key_d;
    rslot_q      <= rslot_d;
    rd_ok_q      <= rd_ok_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_key_q    <= res_key_d;
    res_occ_q    <= res_occ_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_key_q    <= out_key_d;
    out_occ_q    <= out_occ_d;
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot       = out_slot_q;
  assign out_o.stored_key = out_key_q;
  assign out_o.occupied   = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(TableSize))
    else $error("entry count exceeds the table size");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> 32'(idx_q) < TableSize)
    else $error("probe index outside the table");

  a_write_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && ram_we) |-> !slot_busy)
    else $error("insert overwrote an occupied slot");

  a_count_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && !slot_busy) |=> count_q == $past(count_q) + COUNT_W'(1))
    else $error("entry count not advanced on insert");

  a_inserted_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_INSERTED) |-> out_occ_q)
    else $error("inserted result without occupied flag");

endmodule

`default_nettype wire
